>>> rtl/sbcm_pkg.sv
package sbcm_pkg;

	// Screen and sprite limits.
	localparam int SCREEN_COLUMNS  = 640;
	localparam int SCREEN_ROWS     = 480;
	localparam int MAX_SPRITE_SIDE = 256;

	localparam int SIDE_W  = 9;                          // width of a side length, 1..256
	localparam int CNT_W   = $clog2(MAX_SPRITE_SIDE);   // column and row counters
	localparam int CHAN_W  = 9;
	localparam int CENTRE_W = 12;
	localparam int ORIGIN_W = CENTRE_W + 1;              // centre minus half a side
	localparam int POS_W   = ORIGIN_W + 1;               // origin plus offset within the sprite
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int WRITE_X_W = 10;
	localparam int WRITE_Y_W = 9;

	localparam logic [SIDE_W-1:0] MAX_SIDE = SIDE_W'(MAX_SPRITE_SIDE);
	localparam logic signed [POS_W-1:0] X_LIMIT = POS_W'(SCREEN_COLUMNS);
	localparam logic signed [POS_W-1:0] Y_LIMIT = POS_W'(SCREEN_ROWS);
	localparam logic [CHAN_W-1:0] CHAN_KEY = '1;        // -1 in every channel is transparent

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPRITE_WIDTH  = 3'd0,
		REG_SPRITE_HEIGHT = 3'd1,
		REG_CENTER_X      = 3'd2,
		REG_CENTER_Y      = 3'd3,
		REG_FACE_LEFT     = 3'd4
	} cfg_reg_t;

	// Settings as the datapath sees them: sides already clamped, origin already worked out.
	typedef struct packed {
		logic [SIDE_W-1:0]          width;
		logic [SIDE_W-1:0]          height;
		logic signed [ORIGIN_W-1:0] left;
		logic signed [ORIGIN_W-1:0] top;
		logic                       face_left;
	} cfg_t;

	// One pixel held in the first stage, with its position inside the sprite.
	typedef struct packed {
		logic signed [CHAN_W-1:0] red;
		logic signed [CHAN_W-1:0] green;
		logic signed [CHAN_W-1:0] blue;
		logic [CNT_W-1:0]         col;
		logic [CNT_W-1:0]         row;
	} pix_t;

	function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
		logic [SIDE_W-1:0] r;
		if (v == '0) begin
			r = SIDE_W'(1);
		end else if (v > MAX_SIDE) begin
			r = MAX_SIDE;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

>>> rtl/sbcm_cfg.sv
module sbcm_cfg
	import sbcm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	logic [SIDE_W-1:0]   width_q;
	logic [SIDE_W-1:0]   height_q;
	logic [CENTRE_W-1:0] center_x_q;
	logic [CENTRE_W-1:0] center_y_q;
	logic                face_left_q;
	logic [SIDE_W-1:0]   width_c;
	logic [SIDE_W-1:0]   height_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= SIDE_W'(1);
			height_q    <= SIDE_W'(1);
			center_x_q  <= '0;
			center_y_q  <= '0;
			face_left_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SPRITE_WIDTH:  width_q     <= cfg_data[SIDE_W-1:0];
				REG_SPRITE_HEIGHT: height_q    <= cfg_data[SIDE_W-1:0];
				REG_CENTER_X:      center_x_q  <= cfg_data[CENTRE_W-1:0];
				REG_CENTER_Y:      center_y_q  <= cfg_data[CENTRE_W-1:0];
				REG_FACE_LEFT:     face_left_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign width_c  = clamp_side(width_q);
	assign height_c = clamp_side(height_q);

	// The top-left corner sits half a side (rounded down) before the centre.
	always_comb begin
		cfg.width     = width_c;
		cfg.height    = height_c;
		cfg.face_left = face_left_q;
		cfg.left      = $signed({center_x_q[CENTRE_W-1], center_x_q})
		              - $signed({1'b0, 4'b0, width_c[SIDE_W-1:1]});
		cfg.top       = $signed({center_y_q[CENTRE_W-1], center_y_q})
		              - $signed({1'b0, 4'b0, height_c[SIDE_W-1:1]});
	end

endmodule

>>> rtl/sbcm_count.sv
module sbcm_count
	import sbcm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [CHAN_W-1:0] pixel_red,
	input  logic signed [CHAN_W-1:0] pixel_green,
	input  logic signed [CHAN_W-1:0] pixel_blue,
	input  logic                     end_of_sprite,
	input  logic                     take,
	output pix_t                     item_s1,
	output logic                     valid_s1
);

	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;
	logic [CNT_W-1:0] col_eff;
	logic [CNT_W-1:0] row_eff;
	logic [CNT_W-1:0] col_next;
	logic [CNT_W-1:0] row_next;
	logic             accept;
	logic [SIDE_W-1:0] width_m1;
	logic [SIDE_W-1:0] height_m1;

	assign in_ready = !valid_s1 || take;
	assign accept   = in_valid && in_ready;

	assign width_m1  = cfg.width - SIDE_W'(1);
	assign height_m1 = cfg.height - SIDE_W'(1);

	// A counter left over from an earlier, larger sprite is held at the last column or row.
	assign col_eff = ({1'b0, col_q} >= cfg.width)  ? width_m1[CNT_W-1:0]  : col_q;
	assign row_eff = ({1'b0, row_q} >= cfg.height) ? height_m1[CNT_W-1:0] : row_q;

	always_comb begin
		col_next = col_eff + CNT_W'(1);
		row_next = row_eff;
		if (end_of_sprite) begin
			col_next = '0;
			row_next = '0;
		end else if (({1'b0, col_eff} + SIDE_W'(1)) >= cfg.width) begin
			col_next = '0;
			if (({1'b0, row_eff} + SIDE_W'(1)) >= cfg.height) begin
				row_next = '0;
			end else begin
				row_next = row_eff + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (accept) begin
				col_q <= col_next;
				row_q <= row_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.red   <= pixel_red;
			item_s1.green <= pixel_green;
			item_s1.blue  <= pixel_blue;
			item_s1.col   <= col_eff;
			item_s1.row   <= row_eff;
		end
	end

endmodule

>>> rtl/sbcm_place.sv
module sbcm_place
	import sbcm_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  cfg_t                        cfg,
	input  pix_t                        item_s1,
	input  logic                        valid_s1,
	output logic                        take,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [WRITE_X_W-1:0]        write_x,
	output logic [WRITE_Y_W-1:0]        write_y,
	output logic signed [CHAN_W-1:0]    write_red,
	output logic signed [CHAN_W-1:0]    write_green,
	output logic signed [CHAN_W-1:0]    write_blue
);

	logic [SIDE_W-1:0]        mirror_col;
	logic [SIDE_W-1:0]        offset;
	logic signed [POS_W-1:0]  pos_x;
	logic signed [POS_W-1:0]  pos_y;
	logic                     transparent;
	logic                     on_screen;
	logic                     keep;
	logic                     valid_s2;
	logic [WRITE_X_W-1:0]     x_s2;
	logic [WRITE_Y_W-1:0]     y_s2;
	logic signed [CHAN_W-1:0] red_s2;
	logic signed [CHAN_W-1:0] green_s2;
	logic signed [CHAN_W-1:0] blue_s2;

	// The column is already clamped below the width, so the mirrored offset never goes negative.
	assign mirror_col = cfg.width - SIDE_W'(1) - {1'b0, item_s1.col};
	assign offset     = cfg.face_left ? mirror_col : {1'b0, item_s1.col};

	assign pos_x = $signed({cfg.left[ORIGIN_W-1], cfg.left})
	             + $signed({{(POS_W-SIDE_W){1'b0}}, offset});
	assign pos_y = $signed({cfg.top[ORIGIN_W-1], cfg.top})
	             + $signed({{(POS_W-CNT_W){1'b0}}, item_s1.row});

	assign transparent = (item_s1.red == CHAN_KEY) && (item_s1.green == CHAN_KEY)
	                  && (item_s1.blue == CHAN_KEY);
	// Row 0 and column 0 are treated as off screen.
	assign on_screen = (pos_x > 0) && (pos_x < X_LIMIT) && (pos_y > 0) && (pos_y < Y_LIMIT);
	assign keep      = !transparent && on_screen;

	assign take = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take) begin
			valid_s2 <= valid_s1 && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (take && valid_s1 && keep) begin
			x_s2     <= pos_x[WRITE_X_W-1:0];
			y_s2     <= pos_y[WRITE_Y_W-1:0];
			red_s2   <= item_s1.red;
			green_s2 <= item_s1.green;
			blue_s2  <= item_s1.blue;
		end
	end

	assign out_valid   = valid_s2;
	assign write_x     = x_s2;
	assign write_y     = y_s2;
	assign write_red   = red_s2;
	assign write_green = green_s2;
	assign write_blue  = blue_s2;

endmodule

>>> rtl/sprite_blit_color_key_mirror.sv
// Channel   Handshake              Beat carries
// input     in_valid / in_ready    pixel_red, pixel_green, pixel_blue, end_of_sprite
// output    out_valid / out_ready  write_x, write_y, write_red, write_green, write_blue
// config    cfg_we                 cfg_index, cfg_data (no wait, no read-back)
//
// One pixel per clock while the output is not stalled: an accepted pixel passes through the
// position register into the output register, which then offers its canvas write.
// Transparent and off-screen pixels leave no beat but still advance the counters.
// A stalled output holds its beat while one more pixel waits in the position register;
// input ready is low only when both are full and the output is not being taken.
// Reset clears the counters and valid flags and sets the registers to a 1x1 sprite at 0,0.
module sprite_blit_color_key_mirror
	import sbcm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [CHAN_W-1:0] pixel_red,
	input  logic signed [CHAN_W-1:0] pixel_green,
	input  logic signed [CHAN_W-1:0] pixel_blue,
	input  logic                     end_of_sprite,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [WRITE_X_W-1:0]     write_x,
	output logic [WRITE_Y_W-1:0]     write_y,
	output logic signed [CHAN_W-1:0] write_red,
	output logic signed [CHAN_W-1:0] write_green,
	output logic signed [CHAN_W-1:0] write_blue
);

	cfg_t cfg;
	pix_t item_s1;
	logic valid_s1;
	logic take;

	sbcm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sbcm_count u_count (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.pixel_red     (pixel_red),
		.pixel_green   (pixel_green),
		.pixel_blue    (pixel_blue),
		.end_of_sprite (end_of_sprite),
		.take          (take),
		.item_s1       (item_s1),
		.valid_s1      (valid_s1)
	);

	sbcm_place u_place (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.item_s1     (item_s1),
		.valid_s1    (valid_s1),
		.take        (take),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.write_x     (write_x),
		.write_y     (write_y),
		.write_red   (write_red),
		.write_green (write_green),
		.write_blue  (write_blue)
	);

endmodule

>>> rtl/sbcm_checker.sv
module sbcm_checker
	import sbcm_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [WRITE_X_W-1:0]     write_x,
	input logic [WRITE_Y_W-1:0]     write_y,
	input logic signed [CHAN_W-1:0] write_red,
	input logic signed [CHAN_W-1:0] write_green,
	input logic signed [CHAN_W-1:0] write_blue
);

	// A stalled output beat must not change.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(write_x) && $stable(write_y)
		&& $stable(write_red) && $stable(write_green) && $stable(write_blue))
		else $error("output beat changed while stalled");

	// Every write lands inside the screen, away from row 0 and column 0.
	a_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> write_x != '0 && {22'b0, write_x} < SCREEN_COLUMNS
		&& write_y != '0 && {23'b0, write_y} < SCREEN_ROWS)
		else $error("write outside the screen");

	// The colour key never reaches the canvas.
	a_no_key: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(write_red == CHAN_KEY && write_green == CHAN_KEY
		&& write_blue == CHAN_KEY))
		else $error("transparent pixel written");

	// With the output register empty the input side always has room.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty output");

endmodule

bind sprite_blit_color_key_mirror sbcm_checker u_sbcm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.write_x     (write_x),
	.write_y     (write_y),
	.write_red   (write_red),
	.write_green (write_green),
	.write_blue  (write_blue)
);
